### rtl/core/cfadd_pkg.sv
// ----------------------------------------------------------------------------
// cfadd_pkg: shared definitions for the custom float adder
// Holds the stored word width and the bit-order helper used on both sides
// of the adder datapath.
// ----------------------------------------------------------------------------
package cfadd_pkg;

    // Width of one stored float word.
    localparam int WORD_BITS = 32;

    typedef logic [WORD_BITS-1:0] word_t;

    // Reverse the bit order of a stored word (bit i goes to bit 31 - i).
    function automatic word_t bit_reverse(input word_t w);
        word_t r;
        for (int i = 0; i < WORD_BITS; i++) begin
            r[i] = w[WORD_BITS-1-i];
        end
        return r;
    endfunction

endpackage

### rtl/core/custom_float_adder.sv
// ----------------------------------------------------------------------------
// custom_float_adder: adder for a bit-reversed custom float format
// Five-stage pipeline: input register, exponent alignment, mantissa
// add/subtract, carry fix-up with leading-zero count, left normalize and pack.
// ----------------------------------------------------------------------------
// The block adds two custom float words and returns their sum. Each word is
// stored bit-reversed; in the logical word the sign sits above the exponent
// (bias 2^(EXP_BITS-1) - 1) and the low MANT_BITS bits are the mantissa with
// an always-set hidden bit. There is no rounding and no special value. A zero
// sum, or one whose exponent would drop below zero, comes out as all zeros;
// an exponent above its maximum saturates and raises m_overflow. The pipeline
// accepts one beat per clock and raises m_valid for each result once its
// beat has passed the alignment, sum, leading-zero and output registers. A
// stage moves forward whenever the stage ahead is empty or moving, so the
// rate is set only by m_ready; a stage holds while the one ahead is stalled.
// ----------------------------------------------------------------------------
module custom_float_adder
    import cfadd_pkg::*;
#(
    parameter int MANT_BITS = 26,
    parameter int EXP_BITS  = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_BITS-1:0] s_operand_a,
    input  logic [WORD_BITS-1:0] s_operand_b,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_BITS-1:0] m_sum_word,
    output logic                 m_overflow
);

    // Derived widths.
    localparam int MW       = MANT_BITS + 1;      // mantissa with hidden bit
    localparam int SW       = MANT_BITS + 2;      // sum with carry bit
    localparam int EW       = EXP_BITS + 1;       // exponent with headroom
    localparam int LZW      = $clog2(MW);
    localparam int SIGN_POS = MANT_BITS + EXP_BITS;

    // ------------------------------------------------------------------
    // Stage valid bits and advance chain.
    // ------------------------------------------------------------------
    logic vin_reg, val_reg, vsum_reg, vlz_reg, vout_reg;
    logic adv_in, adv_al, adv_sum, adv_lz, adv_out;

    assign adv_out = !vout_reg || m_ready;
    assign adv_lz  = !vlz_reg  || adv_out;
    assign adv_sum = !vsum_reg || adv_lz;
    assign adv_al  = !val_reg  || adv_sum;
    assign adv_in  = !vin_reg  || adv_al;

    assign s_ready = adv_in;
    assign m_valid = vout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vin_reg  <= 1'b0;
            val_reg  <= 1'b0;
            vsum_reg <= 1'b0;
            vlz_reg  <= 1'b0;
            vout_reg <= 1'b0;
        end else begin
            if (adv_in)  vin_reg  <= s_valid;
            if (adv_al)  val_reg  <= vin_reg;
            if (adv_sum) vsum_reg <= val_reg;
            if (adv_lz)  vlz_reg  <= vsum_reg;
            if (adv_out) vout_reg <= vlz_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    word_t a_reg, b_reg;

    always_ff @(posedge aclk) begin
        if (adv_in) begin
            a_reg <= s_operand_a;
            b_reg <= s_operand_b;
        end
    end

    // ------------------------------------------------------------------
    // Unpack and align the operand with the smaller exponent.
    // ------------------------------------------------------------------
    word_t               la, lb;
    logic [EXP_BITS-1:0] ea, eb, diff;
    logic [MW-1:0]       ma, mb;
    logic [MW-1:0]       ma_al_next, mb_al_next;
    logic [EXP_BITS-1:0] e_al_next;
    logic                too_far;

    always_comb begin
        la = bit_reverse(a_reg);
        lb = bit_reverse(b_reg);
        ea = la[MANT_BITS +: EXP_BITS];
        eb = lb[MANT_BITS +: EXP_BITS];
        ma = {1'b1, la[MANT_BITS-1:0]};
        mb = {1'b1, lb[MANT_BITS-1:0]};
        ma_al_next = ma;
        mb_al_next = mb;
        if (ea < eb) begin
            diff      = eb - ea;
            too_far   = (32'(diff) >= 32'(MW));
            ma_al_next = too_far ? '0 : (ma >> diff);
            e_al_next  = eb;
        end else begin
            diff      = ea - eb;
            too_far   = (32'(diff) >= 32'(MW));
            mb_al_next = too_far ? '0 : (mb >> diff);
            e_al_next  = ea;
        end
    end

    logic [MW-1:0]       ma_al_reg, mb_al_reg;
    logic [EXP_BITS-1:0] e_al_reg;
    logic                sa_al_reg, sb_al_reg;

    always_ff @(posedge aclk) begin
        if (adv_al) begin
            ma_al_reg <= ma_al_next;
            mb_al_reg <= mb_al_next;
            e_al_reg  <= e_al_next;
            sa_al_reg <= la[SIGN_POS];
            sb_al_reg <= lb[SIGN_POS];
        end
    end

    // ------------------------------------------------------------------
    // Add on like signs, else subtract the smaller from the larger.
    // ------------------------------------------------------------------
    logic [SW-1:0] m_sum_next;
    logic          s_sum_next;

    always_comb begin
        if (sa_al_reg == sb_al_reg) begin
            m_sum_next = {1'b0, ma_al_reg} + {1'b0, mb_al_reg};
            s_sum_next = sa_al_reg;
        end else if (ma_al_reg > mb_al_reg) begin
            m_sum_next = {1'b0, ma_al_reg - mb_al_reg};
            s_sum_next = sa_al_reg;
        end else begin
            m_sum_next = {1'b0, mb_al_reg - ma_al_reg};
            s_sum_next = sb_al_reg;
        end
    end

    logic [SW-1:0]       m_sum_reg;
    logic                s_sum_reg;
    logic [EXP_BITS-1:0] e_sum_reg;

    always_ff @(posedge aclk) begin
        if (adv_sum) begin
            m_sum_reg <= m_sum_next;
            s_sum_reg <= s_sum_next;
            e_sum_reg <= e_al_reg;
        end
    end

    // ------------------------------------------------------------------
    // Carry fix-up and leading-zero count below the carry position.
    // ------------------------------------------------------------------
    logic [MW-1:0]  m_lz_next;
    logic [EW-1:0]  e_lz_next;
    logic [LZW-1:0] lz_next;
    logic           zero_next;
    logic           found;

    always_comb begin
        zero_next = (m_sum_reg == '0);
        if (m_sum_reg[SW-1]) begin
            m_lz_next = m_sum_reg[SW-1:1];
            e_lz_next = {1'b0, e_sum_reg} + EW'(1);
        end else begin
            m_lz_next = m_sum_reg[MW-1:0];
            e_lz_next = {1'b0, e_sum_reg};
        end
        lz_next = '0;
        found   = 1'b0;
        for (int i = MW - 1; i >= 0; i--) begin
            if (!found && m_lz_next[i]) begin
                lz_next = LZW'(MW - 1 - i);
                found   = 1'b1;
            end
        end
    end

    logic [MW-1:0]  m_lz_reg;
    logic [EW-1:0]  e_lz_reg;
    logic [LZW-1:0] lz_reg;
    logic           zero_lz_reg;
    logic           s_lz_reg;

    always_ff @(posedge aclk) begin
        if (adv_lz) begin
            m_lz_reg    <= m_lz_next;
            e_lz_reg    <= e_lz_next;
            lz_reg      <= lz_next;
            zero_lz_reg <= zero_next;
            s_lz_reg    <= s_sum_reg;
        end
    end

    // ------------------------------------------------------------------
    // Left normalize, check exponent range, pack and reverse.
    // ------------------------------------------------------------------
    logic [MW-1:0]       m_norm;
    logic [EW-1:0]       e_norm;
    logic [EXP_BITS-1:0] e_pack;
    logic                underflow;
    logic                ovf_next;
    word_t               word_logical;
    word_t               sum_next;

    always_comb begin
        m_norm    = m_lz_reg << lz_reg;
        underflow = (32'(lz_reg) > 32'(e_lz_reg));
        e_norm    = e_lz_reg - EW'(lz_reg);
        ovf_next  = 1'b0;
        e_pack    = e_norm[EXP_BITS-1:0];
        if (e_norm[EW-1]) begin
            e_pack   = '1;
            ovf_next = 1'b1;
        end
        word_logical                        = '0;
        word_logical[MANT_BITS-1:0]         = m_norm[MANT_BITS-1:0];
        word_logical[MANT_BITS +: EXP_BITS] = e_pack;
        word_logical[SIGN_POS]              = s_lz_reg;
        if (zero_lz_reg || underflow) begin
            word_logical = '0;
            ovf_next     = 1'b0;
        end
        sum_next = bit_reverse(word_logical);
    end

    word_t sum_reg;
    logic  ovf_reg;

    always_ff @(posedge aclk) begin
        if (adv_out) begin
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
        end
    end

    assign m_sum_word = sum_reg;
    assign m_overflow = ovf_reg;

endmodule
